@@ hw/rtl/hfc_pkg.sv @@
// hfc_pkg: request/result types, config struct and code constants
// for the hysteresis fan controller; no dependencies
package hfc_pkg;

    // request kinds
    localparam logic [2:0] KIND_TEMP   = 3'd0;
    localparam logic [2:0] KIND_RELAY  = 3'd1;
    localparam logic [2:0] KIND_RESULT = 3'd2;
    localparam logic [2:0] KIND_MANUAL = 3'd3;
    localparam logic [2:0] KIND_TICK   = 3'd4;
    localparam logic [2:0] KIND_FORCE  = 3'd5;

    // result events
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_STALE = 3'd1;
    localparam logic [2:0] EV_EVAL  = 3'd2;
    localparam logic [2:0] EV_CMD   = 3'd3;
    localparam logic [2:0] EV_DONE  = 3'd4;
    localparam logic [2:0] EV_ERR   = 3'd5;

    // threshold codes
    localparam logic [1:0] THR_NONE = 2'd0;
    localparam logic [1:0] THR_MAX  = 2'd1;
    localparam logic [1:0] THR_MIN  = 2'd2;

    // control states
    localparam logic [2:0] CS_DISABLED = 3'd0;
    localparam logic [2:0] CS_IDLE     = 3'd1;
    localparam logic [2:0] CS_COOLING  = 3'd2;
    localparam logic [2:0] CS_STALE    = 3'd3;
    localparam logic [2:0] CS_ERROR    = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_RULE_SETUP      = 3'd0;
    localparam logic [2:0] CFG_RULE_ACTIVE     = 3'd1;
    localparam logic [2:0] CFG_MIN_CENTI       = 3'd2;
    localparam logic [2:0] CFG_MAX_CENTI       = 3'd3;
    localparam logic [2:0] CFG_STALE_LIMIT     = 3'd4;
    localparam logic [2:0] CFG_POLL_INTERVAL   = 3'd5;
    localparam logic [2:0] CFG_FALLBACK_POLL   = 3'd6;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] temperature;
        logic               targets_rule;
        logic               switch_on;
        logic               succeeded;
    } t_req;

    typedef struct packed {
        logic [2:0] event_res;
        logic       cmd_fan_on;
        logic [1:0] threshold_hit;
        logic [2:0] ctl_state;
        logic       relay_shown_known;
        logic       relay_shown_on;
        logic       poll_request;
    } t_res;

    typedef struct packed {
        logic               rule_setup;
        logic               rule_active;
        logic signed [14:0] min_centi;
        logic signed [14:0] max_centi;
        logic [15:0]        stale_limit;
        logic [15:0]        poll_interval;
        logic               fallback_poll;
    } t_cfg;

endpackage

@@ hw/rtl/hfc_cfg.sv @@
// hfc_cfg: configuration register file, write only
// depends on hfc_pkg
module hfc_cfg
    import hfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output logic                  o_poll_clr
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rule_setup      <= 1'b0;
            r_cfg.rule_active     <= 1'b0;
            r_cfg.min_centi       <= 15'sd2400;
            r_cfg.max_centi       <= 15'sd2800;
            r_cfg.stale_limit     <= 16'd70;
            r_cfg.poll_interval   <= 16'd30;
            r_cfg.fallback_poll   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RULE_SETUP:      r_cfg.rule_setup      <= i_cfg_data[0];
                CFG_RULE_ACTIVE:     r_cfg.rule_active     <= i_cfg_data[0];
                CFG_MIN_CENTI:       r_cfg.min_centi       <= i_cfg_data[14:0];
                CFG_MAX_CENTI:       r_cfg.max_centi       <= i_cfg_data[14:0];
                CFG_STALE_LIMIT:     r_cfg.stale_limit     <= i_cfg_data;
                CFG_POLL_INTERVAL:   r_cfg.poll_interval   <= i_cfg_data;
                CFG_FALLBACK_POLL:   r_cfg.fallback_poll   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg      = r_cfg;
    // rewriting the fallback flag makes a poll due at the next tick
    assign o_poll_clr = i_cfg_we && (i_cfg_idx == CFG_FALLBACK_POLL);

endmodule

@@ hw/rtl/hfc_core.sv @@
// hfc_core: controller state registers and the single-pass update logic
// depends on hfc_pkg
module hfc_core
    import hfc_pkg::*;
#(
    parameter int AGE_BITS  = 16,
    parameter int TEMP_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_req i_req,
    input  t_cfg i_cfg,
    input  logic i_poll_clr,
    output t_res o_res
);

    localparam int SAT_W = (TEMP_BITS > 16) ? TEMP_BITS : 16;
    localparam int CMP_W = (TEMP_BITS > 15) ? TEMP_BITS : 15;
    localparam int LIM_W = (AGE_BITS > 16) ? AGE_BITS : 16;
    localparam logic signed [SAT_W-1:0] T_HI = SAT_W'((1 << (TEMP_BITS - 1)) - 1);
    localparam logic signed [SAT_W-1:0] T_LO = ~T_HI;

    logic                        r_have_temp, n_have_temp;
    logic signed [TEMP_BITS-1:0] r_last_temp, n_last_temp;
    logic [AGE_BITS-1:0]         r_temp_age, n_temp_age;
    logic                        r_relay_rep, n_relay_rep;
    logic                        r_relay_rep_on, n_relay_rep_on;
    logic                        r_last_cmd_known, n_last_cmd_known;
    logic                        r_last_cmd_on, n_last_cmd_on;
    logic                        r_cmd_pending, n_cmd_pending;
    logic                        r_pending_on, n_pending_on;
    logic [2:0]                  r_ctrl_state, n_ctrl_state;
    logic [AGE_BITS-1:0]         r_poll_age, n_poll_age;
    logic                        r_polled_once, n_polled_once;

    logic signed [SAT_W-1:0]     temp_ext;
    logic signed [TEMP_BITS-1:0] temp_sat;
    logic signed [CMP_W-1:0]     t_cmp, min_cmp, max_cmp;
    logic                        rule_on;
    logic                        do_eval, force_eval, stale;
    logic                        want, hit;
    logic [1:0]                  thr;
    logic [1:0]                  eff;
    t_res                        res;

    // effective relay state: reported, then pending, then last command
    function automatic logic [1:0] relay_eff(
        input logic rep, input logic rep_on,
        input logic pend, input logic pend_on,
        input logic last_known, input logic last_on
    );
        logic [1:0] r;
        if (rep)             r = {1'b1, rep_on};
        else if (pend)       r = {1'b1, pend_on};
        else if (last_known) r = {1'b1, last_on};
        else                 r = 2'b00;
        return r;
    endfunction

    function automatic logic is_stale(
        input logic have, input logic [AGE_BITS-1:0] age, input logic [15:0] limit
    );
        return !have || (LIM_W'(age) > LIM_W'(limit));
    endfunction

    function automatic logic [AGE_BITS-1:0] age_inc(input logic [AGE_BITS-1:0] a);
        return (a == '1) ? a : a + 1'b1;
    endfunction

    // clamp the 16 bit report into the stored width
    always_comb begin
        temp_ext = SAT_W'(i_req.temperature);
        if (temp_ext > T_HI)      temp_sat = TEMP_BITS'(T_HI);
        else if (temp_ext < T_LO) temp_sat = TEMP_BITS'(T_LO);
        else                      temp_sat = TEMP_BITS'(temp_ext);
    end

    assign rule_on = i_cfg.rule_setup && i_cfg.rule_active;

    always_comb begin
        n_have_temp      = r_have_temp;
        n_last_temp      = r_last_temp;
        n_temp_age       = r_temp_age;
        n_relay_rep      = r_relay_rep;
        n_relay_rep_on   = r_relay_rep_on;
        n_last_cmd_known = r_last_cmd_known;
        n_last_cmd_on    = r_last_cmd_on;
        n_cmd_pending    = r_cmd_pending;
        n_pending_on     = r_pending_on;
        n_ctrl_state     = r_ctrl_state;
        n_poll_age       = r_poll_age;
        n_polled_once    = r_polled_once;
        res              = '0;
        do_eval          = 1'b0;
        force_eval       = 1'b0;
        stale            = 1'b0;
        want             = 1'b0;
        hit              = 1'b0;
        thr              = THR_NONE;
        eff              = 2'b00;
        t_cmp            = '0;
        min_cmp          = '0;
        max_cmp          = '0;

        case (i_req.kind)
            KIND_TEMP: begin
                n_have_temp = 1'b1;
                n_last_temp = temp_sat;
                n_temp_age  = '0;
                do_eval     = i_req.targets_rule && i_cfg.rule_setup;
            end
            KIND_RELAY: begin
                n_relay_rep    = 1'b1;
                n_relay_rep_on = i_req.switch_on;
            end
            KIND_RESULT: begin
                if (r_cmd_pending && (r_pending_on == i_req.switch_on)) begin
                    n_cmd_pending = 1'b0;
                end
                if (i_req.succeeded) begin
                    n_last_cmd_known = 1'b1;
                    n_last_cmd_on    = i_req.switch_on;
                    n_ctrl_state     = i_req.switch_on ? CS_COOLING : CS_IDLE;
                    res.event_res    = EV_DONE;
                    res.cmd_fan_on   = i_req.switch_on;
                end else begin
                    n_ctrl_state  = CS_ERROR;
                    res.event_res = EV_ERR;
                end
            end
            KIND_MANUAL: begin
                if (i_cfg.rule_setup && i_req.targets_rule) begin
                    n_last_cmd_known = 1'b1;
                    n_last_cmd_on    = i_req.switch_on;
                    n_cmd_pending    = 1'b0;
                    if (i_cfg.rule_active) begin
                        n_ctrl_state = i_req.switch_on ? CS_COOLING : CS_IDLE;
                    end else begin
                        n_ctrl_state = CS_DISABLED;
                    end
                end
            end
            KIND_TICK: begin
                n_temp_age = age_inc(r_temp_age);
                n_poll_age = age_inc(r_poll_age);
                if (rule_on && is_stale(r_have_temp, n_temp_age, i_cfg.stale_limit)
                        && (r_ctrl_state != CS_STALE)) begin
                    n_ctrl_state  = CS_STALE;
                    res.event_res = EV_STALE;
                end
                if (rule_on && i_cfg.fallback_poll && (!r_polled_once
                        || (LIM_W'(n_poll_age) >= LIM_W'(i_cfg.poll_interval)))) begin
                    n_polled_once    = 1'b1;
                    n_poll_age       = '0;
                    res.poll_request = 1'b1;
                end
            end
            KIND_FORCE: begin
                do_eval    = 1'b1;
                force_eval = 1'b1;
            end
            default: ;
        endcase

        // threshold evaluation on the updated temperature
        if (do_eval) begin
            stale   = is_stale(n_have_temp, n_temp_age, i_cfg.stale_limit);
            t_cmp   = CMP_W'(n_last_temp);
            min_cmp = CMP_W'(i_cfg.min_centi);
            max_cmp = CMP_W'(i_cfg.max_centi);
            eff     = relay_eff(n_relay_rep, n_relay_rep_on, n_cmd_pending,
                                n_pending_on, n_last_cmd_known, n_last_cmd_on);
            if (t_cmp >= max_cmp) begin
                want = 1'b1;
                thr  = THR_MAX;
                hit  = 1'b1;
            end else if (t_cmp <= min_cmp) begin
                want = 1'b0;
                thr  = THR_MIN;
                hit  = 1'b1;
            end
            if (!rule_on) begin
                n_ctrl_state = CS_DISABLED;
            end else if (stale) begin
                if (n_ctrl_state != CS_STALE) res.event_res = EV_STALE;
                n_ctrl_state = CS_STALE;
            end else if (!hit) begin
                n_ctrl_state  = eff[0] ? CS_COOLING : CS_IDLE;
                res.event_res = EV_EVAL;
            end else if (eff[1] && (eff[0] == want) && !force_eval) begin
                n_ctrl_state  = want ? CS_COOLING : CS_IDLE;
                res.event_res = EV_EVAL;
            end else begin
                n_cmd_pending     = 1'b1;
                n_pending_on      = want;
                res.event_res     = EV_CMD;
                res.cmd_fan_on    = want;
                res.threshold_hit = thr;
            end
        end

        res.ctl_state = n_ctrl_state;
        {res.relay_shown_known, res.relay_shown_on} =
            relay_eff(n_relay_rep, n_relay_rep_on, n_cmd_pending,
                      n_pending_on, n_last_cmd_known, n_last_cmd_on);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_temp      <= 1'b0;
            r_last_temp      <= '0;
            r_temp_age       <= '0;
            r_relay_rep      <= 1'b0;
            r_relay_rep_on   <= 1'b0;
            r_last_cmd_known <= 1'b0;
            r_last_cmd_on    <= 1'b0;
            r_cmd_pending    <= 1'b0;
            r_pending_on     <= 1'b0;
            r_ctrl_state     <= CS_DISABLED;
            r_poll_age       <= '0;
            r_polled_once    <= 1'b0;
        end else begin
            if (i_fire) begin
                r_have_temp      <= n_have_temp;
                r_last_temp      <= n_last_temp;
                r_temp_age       <= n_temp_age;
                r_relay_rep      <= n_relay_rep;
                r_relay_rep_on   <= n_relay_rep_on;
                r_last_cmd_known <= n_last_cmd_known;
                r_last_cmd_on    <= n_last_cmd_on;
                r_cmd_pending    <= n_cmd_pending;
                r_pending_on     <= n_pending_on;
                r_ctrl_state     <= n_ctrl_state;
                r_poll_age       <= n_poll_age;
            end
            if (i_poll_clr) begin
                r_polled_once <= 1'b0;
            end else if (i_fire) begin
                r_polled_once <= n_polled_once;
            end
        end
    end

    assign o_res = res;

endmodule

@@ hw/rtl/hysteresis_fan_controller_unit.sv @@
// hysteresis_fan_controller_unit: top level with request/result handshakes, uses hfc_pkg
// path: an accepted request waits in the input register, then its result goes to the result register
// throughput: one request per cycle, set by the single-pass update between the two registers;
// a stalled result blocks new requests only once the input register is also occupied
// reset: synchronous active-low i_rst_n clears both valid flags, controller state and
// configuration registers to their defaults (rule off, thresholds 24.00 and 28.00)
module hysteresis_fan_controller_unit
    import hfc_pkg::*;
#(
    parameter int AGE_BITS  = 16,
    parameter int TEMP_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_req                  i_in_req,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_res                  o_out_res,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // input register holds one request until the core can retire it
    logic r_in_valid;
    t_req r_in_req;
    // result register faces the downstream side
    logic r_out_valid;
    t_res r_out_res;

    t_cfg cfg;
    logic poll_clr;
    t_res core_res;

    logic out_take;   // result register can load this cycle
    logic advance;    // request in the input register is processed now
    logic accept;     // new request enters the input register

    assign out_take   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_take;
    // stall only when a request is parked and the result register is blocked
    assign o_in_stall = r_in_valid && !out_take;
    assign accept     = i_in_valid && !o_in_stall;

    hfc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_poll_clr (poll_clr)
    );

    // state updates only when the request actually moves to the result register
    hfc_core #(
        .AGE_BITS  (AGE_BITS),
        .TEMP_BITS (TEMP_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (advance),
        .i_req      (r_in_req),
        .i_cfg      (cfg),
        .i_poll_clr (poll_clr),
        .o_res      (core_res)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_req <= i_in_req;
        end
        if (advance) begin
            r_out_res <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    // a threshold code only travels with a command request
    a_thr_only_on_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_res.threshold_hit != THR_NONE) |->
            (r_out_res.event_res == EV_CMD))
        else $error("threshold code without command request");

    // unknown relay state never shows as on
    a_relay_unknown_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_res.relay_shown_known |-> !r_out_res.relay_shown_on)
        else $error("relay shown on while unknown");

    // an accepted request is held in the input register next cycle
    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_in_valid)
        else $error("accepted request lost");

    // a request that advances always produces a valid result next cycle
    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed request produced no result");

    // a poll request only comes out with fallback polling on
    a_poll_needs_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && core_res.poll_request |-> cfg.fallback_poll && cfg.rule_active)
        else $error("poll request without fallback polling");

endmodule

@@ tb/sv/tb_hysteresis_fan_controller_unit.sv @@
// tb_hysteresis_fan_controller_unit: self-checking bench for the hysteresis fan controller
// a directed table and then random request streams, checked against an in-bench controller model
// depends on hfc_pkg and hysteresis_fan_controller_unit
`timescale 1ns / 100ps

module tb_hysteresis_fan_controller_unit;
    import hfc_pkg::*;

    // kinds outside the defined set, the block must ignore them
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_req                  i_in_req = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_res                  o_out_res;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    hysteresis_fan_controller_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------
    // controller model: configuration copy and state, reset values
    // ---------------------------------------------------------------
    logic               cfg_configured = 1'b0;
    logic               cfg_enabled    = 1'b0;
    logic signed [14:0] cfg_min        = 15'sd2400;
    logic signed [14:0] cfg_max        = 15'sd2800;
    logic [15:0]        cfg_stale      = 16'd70;
    logic [15:0]        cfg_poll       = 16'd30;
    logic               cfg_fallback   = 1'b0;

    logic               st_have_temp  = 1'b0;
    logic signed [15:0] st_last_temp  = '0;
    logic [15:0]        st_temp_age   = '0;
    logic               st_rep        = 1'b0;
    logic               st_rep_on     = 1'b0;
    logic               st_last_known = 1'b0;
    logic               st_last_on    = 1'b0;
    logic               st_pending    = 1'b0;
    logic               st_pending_on = 1'b0;
    logic [2:0]         st_ctrl       = CS_DISABLED;
    logic [15:0]        st_poll_age   = '0;
    logic               st_polled     = 1'b0;

    t_res reaction_q[$];
    int   fail_count = 0;
    int   in_idle_pct = 14;
    int   out_stall_pct = 65;

    function automatic logic [15:0] age_step(input logic [15:0] a);
        return (a == 16'hFFFF) ? a : a + 16'd1;
    endfunction

    function automatic logic temp_is_stale();
        return !st_have_temp || (st_temp_age > cfg_stale);
    endfunction

    // effective relay: reported, else pending, else last commanded
    function automatic logic eff_known();
        return st_rep || st_pending || st_last_known;
    endfunction

    function automatic logic eff_on();
        if (st_rep) return st_rep_on;
        if (st_pending) return st_pending_on;
        if (st_last_known) return st_last_on;
        return 1'b0;
    endfunction

    function automatic void eval_rule(input logic forced, inout t_res res);
        logic       want;
        logic [1:0] thr;
        int         t;
        int         lo;
        int         hi;
        t  = st_last_temp;
        lo = cfg_min;
        hi = cfg_max;
        if (!cfg_configured || !cfg_enabled) begin
            st_ctrl = CS_DISABLED;
            return;
        end
        if (temp_is_stale()) begin
            if (st_ctrl != CS_STALE) res.event_res = EV_STALE;
            st_ctrl = CS_STALE;
            return;
        end
        // max wins when the thresholds are inverted
        if (t >= hi) begin
            want = 1'b1;
            thr  = THR_MAX;
        end else if (t <= lo) begin
            want = 1'b0;
            thr  = THR_MIN;
        end else begin
            st_ctrl       = eff_on() ? CS_COOLING : CS_IDLE;
            res.event_res = EV_EVAL;
            return;
        end
        if (eff_known() && eff_on() == want && !forced) begin
            st_ctrl       = want ? CS_COOLING : CS_IDLE;
            res.event_res = EV_EVAL;
            return;
        end
        st_pending        = 1'b1;
        st_pending_on     = want;
        res.event_res     = EV_CMD;
        res.cmd_fan_on    = want;
        res.threshold_hit = thr;
    endfunction

    // controller reaction to one request, advances the model state
    function automatic t_res ctrl_reaction(input t_req r);
        t_res res;
        res = '0;
        case (r.kind)
            KIND_TEMP: begin
                st_have_temp = 1'b1;
                st_last_temp = r.temperature;
                st_temp_age  = '0;
                if (r.targets_rule && cfg_configured) eval_rule(1'b0, res);
            end
            KIND_RELAY: begin
                st_rep    = 1'b1;
                st_rep_on = r.switch_on;
            end
            KIND_RESULT: begin
                if (st_pending && st_pending_on == r.switch_on) st_pending = 1'b0;
                if (r.succeeded) begin
                    st_last_known  = 1'b1;
                    st_last_on     = r.switch_on;
                    st_ctrl        = r.switch_on ? CS_COOLING : CS_IDLE;
                    res.event_res  = EV_DONE;
                    res.cmd_fan_on = r.switch_on;
                end else begin
                    st_ctrl       = CS_ERROR;
                    res.event_res = EV_ERR;
                end
            end
            KIND_MANUAL: begin
                if (cfg_configured && r.targets_rule) begin
                    st_last_known = 1'b1;
                    st_last_on    = r.switch_on;
                    st_pending    = 1'b0;
                    st_ctrl = cfg_enabled ? (r.switch_on ? CS_COOLING : CS_IDLE) : CS_DISABLED;
                end
            end
            KIND_TICK: begin
                st_temp_age = age_step(st_temp_age);
                st_poll_age = age_step(st_poll_age);
                if (cfg_configured && cfg_enabled && temp_is_stale() && st_ctrl != CS_STALE) begin
                    st_ctrl       = CS_STALE;
                    res.event_res = EV_STALE;
                end
                if (cfg_configured && cfg_enabled && cfg_fallback &&
                    (!st_polled || st_poll_age >= cfg_poll)) begin
                    st_polled        = 1'b1;
                    st_poll_age      = '0;
                    res.poll_request = 1'b1;
                end
            end
            KIND_FORCE: eval_rule(1'b1, res);
            default: ;
        endcase
        res.ctl_state         = st_ctrl;
        res.relay_shown_known = eff_known();
        res.relay_shown_on    = eff_on();
        return res;
    endfunction

    function automatic void cfg_apply(input logic [2:0] idx, input logic [15:0] val);
        case (idx)
            CFG_RULE_SETUP:      cfg_configured = val[0];
            CFG_RULE_ACTIVE:     cfg_enabled    = val[0];
            CFG_MIN_CENTI:       cfg_min        = val[14:0];
            CFG_MAX_CENTI:       cfg_max        = val[14:0];
            CFG_STALE_LIMIT:     cfg_stale      = val;
            CFG_POLL_INTERVAL:   cfg_poll       = val;
            CFG_FALLBACK_POLL: begin
                cfg_fallback = val[0];
                st_polled    = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------
    function automatic t_req mk_req(input logic [2:0] kind, input int temp,
                                    input int tgt, input int on, input int ok);
        t_req r;
        r.kind         = kind;
        r.temperature  = 16'(temp);
        r.targets_rule = 1'(tgt);
        r.switch_on    = 1'(on);
        r.succeeded    = 1'(ok);
        return r;
    endfunction

    function automatic t_res mk_res(input logic [2:0] ev, input int on, input logic [1:0] thr,
                                    input logic [2:0] cs, input int known,
                                    input int shown);
        t_res r;
        r = '0;
        r.event_res         = ev;
        r.cmd_fan_on        = 1'(on);
        r.threshold_hit     = thr;
        r.ctl_state         = cs;
        r.relay_shown_known = 1'(known);
        r.relay_shown_on    = 1'(shown);
        return r;
    endfunction

    // idle cycles before the next request, each cycle idles with the set percentage
    function automatic int sender_gap();
        int gap;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct) gap++;
        return gap;
    endfunction

    // present one request, hold it until taken, then log what it should cause
    task automatic send_req(input t_req r, input int gap, input bit typed, input t_res fixed);
        t_res pred;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = ctrl_reaction(r);
        reaction_q.push_back(typed ? fixed : pred);
    endtask

    // stop sending and wait until every logged result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (reaction_q.size() != 0);
    endtask

    // leaves the write enable high, the caller lowers it
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        cfg_apply(idx, val);
    endtask

    task automatic apply_settings(input int conf, input int en, input int mn, input int mx,
                                  input int stale_lim, input int poll_int, input int fb);
        wait_drained();
        write_reg(CFG_RULE_SETUP, 16'(conf));
        write_reg(CFG_RULE_ACTIVE, 16'(en));
        write_reg(CFG_MIN_CENTI, 16'(mn));
        write_reg(CFG_MAX_CENTI, 16'(mx));
        write_reg(CFG_STALE_LIMIT, 16'(stale_lim));
        write_reg(CFG_POLL_INTERVAL, 16'(poll_int));
        write_reg(CFG_FALLBACK_POLL, 16'(fb));
        i_cfg_we <= 1'b0;
    endtask

    // random request, mostly well formed for a configured rule
    function automatic t_req random_req();
        t_req r;
        int   pick;
        int   a;
        int   b;
        int   lo;
        int   hi;
        a = cfg_min;
        b = cfg_max;
        lo = ((a < b) ? a : b) - 300;
        hi = ((a < b) ? b : a) + 300;
        r.kind         = KIND_TICK;
        r.temperature  = 16'($urandom);
        r.targets_rule = ($urandom_range(99) < 85);
        r.switch_on    = 1'($urandom_range(1));
        r.succeeded    = ($urandom_range(99) < 85);
        pick = $urandom_range(99);
        if (pick < 25) begin
            r.kind = KIND_TEMP;
            // keep most temperatures around the dead band
            if ($urandom_range(99) < 70) r.temperature = 16'(lo + int'($urandom_range(hi - lo)));
        end else if (pick < 35) begin
            r.kind = KIND_RELAY;
        end else if (pick < 50) begin
            r.kind = KIND_RESULT;
            if (st_pending && $urandom_range(99) < 70) r.switch_on = st_pending_on;
        end else if (pick < 58) begin
            r.kind = KIND_MANUAL;
        end else if (pick < 88) begin
            r.kind = KIND_TICK;
        end else if (pick < 96) begin
            r.kind = KIND_FORCE;
        end else begin
            r.kind = $urandom_range(1) ? KIND_SPARE6 : KIND_SPARE7;
        end
        return r;
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(99) < out_stall_pct);
    end

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= 200)
            $display("%0t ns: %s: got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (reaction_q.size() == 0) begin
                report_mismatch("result with nothing awaited", o_out_res.event_res, 0);
            end else begin
                want = reaction_q.pop_front();
                if (o_out_res.event_res !== want.event_res)
                    report_mismatch("event_res", o_out_res.event_res, want.event_res);
                if (o_out_res.cmd_fan_on !== want.cmd_fan_on)
                    report_mismatch("cmd_fan_on", o_out_res.cmd_fan_on, want.cmd_fan_on);
                if (o_out_res.threshold_hit !== want.threshold_hit)
                    report_mismatch("threshold_hit", o_out_res.threshold_hit,
                                    want.threshold_hit);
                if (o_out_res.ctl_state !== want.ctl_state)
                    report_mismatch("ctl_state", o_out_res.ctl_state,
                                    want.ctl_state);
                if (o_out_res.relay_shown_known !== want.relay_shown_known)
                    report_mismatch("relay_shown_known", o_out_res.relay_shown_known,
                                    want.relay_shown_known);
                if (o_out_res.relay_shown_on !== want.relay_shown_on)
                    report_mismatch("relay_shown_on", o_out_res.relay_shown_on,
                                    want.relay_shown_on);
                if (o_out_res.poll_request !== want.poll_request)
                    report_mismatch("poll_request", o_out_res.poll_request, want.poll_request);
            end
        end
    end

    // ---------------------------------------------------------------
    // directed table: register writes and requests, some with fixed results
    // ---------------------------------------------------------------
    typedef struct {
        bit         is_reg;
        logic [2:0] reg_idx;
        logic [15:0] reg_val;
        t_req       req;
        bit         typed;
        t_res       res;
    } t_row;

    t_row dir_rows[$];

    function automatic void add_reg(input logic [2:0] idx, input int val);
        t_row w;
        w = '{default: '0};
        w.is_reg  = 1'b1;
        w.reg_idx = idx;
        w.reg_val = 16'(val);
        dir_rows.push_back(w);
    endfunction

    function automatic void add_item(input t_req r);
        t_row w;
        w = '{default: '0};
        w.req = r;
        dir_rows.push_back(w);
    endfunction

    function automatic void add_typed(input t_req r, input t_res e);
        t_row w;
        w = '{default: '0};
        w.req   = r;
        w.typed = 1'b1;
        w.res   = e;
        dir_rows.push_back(w);
    endfunction

    initial begin : stimulus
        t_res quiet;
        bit   reg_open;
        int   set;
        int   n;

        quiet = mk_res(EV_NONE, 0, THR_NONE, CS_DISABLED, 0, 0);

        // right after reset: rule not configured, nothing reacts
        add_typed(mk_req(KIND_TEMP, 2500, 1, 0, 0), quiet);
        add_typed(mk_req(KIND_TICK, 0, 1, 1, 1), quiet);
        add_typed(mk_req(KIND_SPARE6, 0, 0, 0, 0), quiet);
        add_typed(mk_req(KIND_SPARE7, 32767, 1, 1, 1), quiet);
        // widest thresholds, rule on
        add_reg(CFG_RULE_SETUP, 1);
        add_reg(CFG_RULE_ACTIVE, 1);
        add_reg(CFG_MIN_CENTI, -4000);
        add_reg(CFG_MAX_CENTI, 8500);
        add_typed(mk_req(KIND_TEMP, 2500, 1, 0, 0),
                  mk_res(EV_EVAL, 0, THR_NONE, CS_IDLE, 0, 0));
        // hottest report with no relay known: command on
        add_typed(mk_req(KIND_TEMP, 32767, 1, 0, 0),
                  mk_res(EV_CMD, 1, THR_MAX, CS_IDLE, 1, 1));
        // pending state already matches, then forced anyway
        add_item(mk_req(KIND_TEMP, 32767, 1, 0, 0));
        add_item(mk_req(KIND_FORCE, 0, 0, 0, 0));
        add_typed(mk_req(KIND_RESULT, 0, 0, 1, 1),
                  mk_res(EV_DONE, 1, THR_NONE, CS_COOLING, 1, 1));
        add_typed(mk_req(KIND_RESULT, 0, 0, 0, 0),
                  mk_res(EV_ERR, 0, THR_NONE, CS_ERROR, 1, 1));
        // coldest report against the last commanded state
        add_item(mk_req(KIND_TEMP, -32768, 1, 0, 0));
        add_item(mk_req(KIND_MANUAL, 0, 1, 1, 0));
        add_item(mk_req(KIND_MANUAL, 0, 0, 0, 0));
        add_item(mk_req(KIND_TEMP, 3000, 0, 0, 0));
        add_item(mk_req(KIND_TICK, 0, 0, 0, 0));
        // zero stale limit and zero poll interval
        add_reg(CFG_STALE_LIMIT, 0);
        add_reg(CFG_POLL_INTERVAL, 0);
        add_reg(CFG_FALLBACK_POLL, 1);
        add_item(mk_req(KIND_TICK, 0, 0, 0, 0));
        add_item(mk_req(KIND_FORCE, 0, 0, 0, 0));
        add_item(mk_req(KIND_TICK, 0, 0, 0, 0));
        // rule switched off
        add_reg(CFG_RULE_ACTIVE, 0);
        add_item(mk_req(KIND_FORCE, 0, 0, 0, 0));
        add_item(mk_req(KIND_MANUAL, 0, 1, 1, 0));
        // inverted thresholds, largest limits
        add_reg(CFG_RULE_ACTIVE, 1);
        add_reg(CFG_MIN_CENTI, 3000);
        add_reg(CFG_MAX_CENTI, 2000);
        add_reg(CFG_STALE_LIMIT, 65535);
        add_reg(CFG_POLL_INTERVAL, 65535);
        add_item(mk_req(KIND_TEMP, 2500, 1, 0, 0));
        add_item(mk_req(KIND_TEMP, 1000, 1, 0, 0));
        // relay reports take over the effective state
        add_item(mk_req(KIND_RELAY, 0, 0, 1, 0));
        add_item(mk_req(KIND_RELAY, 0, 1, 0, 0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        reg_open = 1'b0;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_reg) begin
                if (!reg_open) wait_drained();
                write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
                reg_open = 1'b1;
            end else begin
                if (reg_open) i_cfg_we <= 1'b0;
                reg_open = 1'b0;
                send_req(dir_rows[k].req, reg_open ? 0 : sender_gap(), dir_rows[k].typed,
                         dir_rows[k].res);
            end
        end

        // random streams: sender idles lightly first, then the receiver, then neither
        for (set = 0; set < 9; set++) begin
            if (set < 3) begin
                in_idle_pct   = 14;
                out_stall_pct = 65;
            end else if (set < 6) begin
                in_idle_pct   = 65;
                out_stall_pct = 14;
            end else begin
                in_idle_pct   = 0;
                out_stall_pct = 0;
            end
            case (set)
                0: apply_settings(1, 1, 2400, 2800, 70, 30, 1);
                1: apply_settings(1, 1, -4000, 8500, 1, 1, 0);
                2: apply_settings(1, 1, -4000, -4000, 5, 3, 1);
                3: apply_settings(0, 1, 2400, 2800, 70, 30, 1);
                4: apply_settings(1, 0, 2400, 2800, 70, 30, 1);
                5: apply_settings(1, 1, 8500, -4000, 65535, 65535, 1);
                default: apply_settings(int'($urandom_range(9) != 0),
                                        int'($urandom_range(9) != 0),
                                        int'($urandom_range(12500)) - 4000,
                                        int'($urandom_range(12500)) - 4000,
                                        int'($urandom_range(1, 200)),
                                        int'($urandom_range(1, 40)),
                                        int'($urandom_range(1)));
            endcase
            for (n = 0; n < 150; n++) begin
                // now and then hold off until the pipeline is empty
                if ($urandom_range(99) < 2) begin
                    wait_drained();
                    send_req(random_req(), 0, 1'b0, '0);
                end else begin
                    send_req(random_req(), sender_gap(), 1'b0, '0);
                end
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (reaction_q.size() != 0)
            report_mismatch("results never delivered", reaction_q.size(), 0);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/hfc_pkg.sv
hw/rtl/hfc_cfg.sv
hw/rtl/hfc_core.sv
hw/rtl/hysteresis_fan_controller_unit.sv
tb/sv/tb_hysteresis_fan_controller_unit.sv
